// ----- rtl/shtp_pkg.sv -----
package shtp_pkg;

  // Table geometry and field widths
  localparam int TABLE_BITS_DEF = 12;
  localparam int SIZE_W         = 4;
  localparam int SIZE_RST       = 12;
  localparam int OP_W           = 2;
  localparam int BYTE_W         = 8;
  localparam int STATUS_W       = 3;
  localparam int SLOT_W         = 12;
  localparam int TAG_W          = 7;
  localparam int ENTRY_W        = TAG_W + 1;

  // Hash seeds and crypt table generator constants
  localparam logic [31:0] SEED_A     = 32'h7FED7FED;
  localparam logic [31:0] SEED_B     = 32'hEEEEEEEE;
  localparam logic [31:0] CRYPT_INIT = 32'h00100001;
  localparam logic [31:0] CRYPT_MUL  = 32'd125;
  localparam logic [31:0] CRYPT_ADD  = 32'd3;
  localparam logic [31:0] CRYPT_MOD  = 32'h002AAAAB;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_FOUND   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOAD,
    S_PROBE,
    S_SWEEP,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    accept;
    logic    probe_load;
    logic    probe_step;
    logic    wr_tag;
    logic    sweep_step;
    logic    res_set;
    logic    res_use_pos;
    status_t res_status;
    logic    out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic occupied;
    logic tag_hit;
    logic wrap;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

  typedef logic [255:0][31:0] rom_t;

  typedef struct packed {
    logic [31:0] one;
    logic [31:0] two;
  } hash_pair_t;

  // One step of the crypt table seed sequence
  function automatic logic [31:0] crypt_step(input logic [31:0] s);
    return (s * CRYPT_MUL + CRYPT_ADD) % CRYPT_MOD;
  endfunction

  // Build one 256-word half of the crypt table: sel 0 offset words, sel 1 tag words
  function automatic rom_t build_rom(input int sel);
    rom_t        r;
    logic [31:0] s;
    logic [31:0] upper;
    r = '0;
    s = CRYPT_INIT;
    for (int a = 0; a < 256; a++) begin
      for (int k = 0; k < 2; k++) begin
        s     = crypt_step(s);
        upper = {s[15:0], 16'h0000};
        s     = crypt_step(s);
        if (k == sel) begin
          r[a] = upper | {16'h0000, s[15:0]};
        end
      end
      // step through the unused hash types
      for (int k = 2; k < 5; k++) begin
        s = crypt_step(s);
        s = crypt_step(s);
      end
    end
    return r;
  endfunction

  localparam rom_t OFS_ROM = build_rom(0);
  localparam rom_t TAG_ROM = build_rom(1);

  // Advance one running hash by one byte
  function automatic hash_pair_t hash_mix(input hash_pair_t h, input logic [31:0] word,
                                          input logic [BYTE_W-1:0] ch);
    hash_pair_t  r;
    logic [31:0] n1;
    n1    = word ^ (h.one + h.two);
    r.two = {24'h0, ch} + n1 + h.two + {h.two[26:0], 5'b00000} + 32'd3;
    r.one = n1;
    return r;
  endfunction

endpackage

// ----- rtl/shtp_ifs.sv -----
interface shtp_req_if import shtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic              has_byte;
  logic [BYTE_W-1:0] key_byte;
  logic              last;

  modport source(output valid, output op, output has_byte, output key_byte, output last,
                 input ready);
  modport sink(input valid, input op, input has_byte, input key_byte, input last,
               output ready);
endinterface

interface shtp_rsp_if import shtp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source(output valid, output status, output slot, input ready);
  modport sink(input valid, input status, input slot, output ready);
endinterface

// ----- rtl/string_hash_table_probe.sv -----
// String hash table probe.
// in_ch carries a key one byte per request (op, has_byte, key_byte, last);
// out_ch carries one result (status, slot) for each request marked last with
// op add, look up or clear. cfg_wr_en/cfg_wr_data write size_log2; the user
// must write it only while idle, the block does not enforce this.
// Bytes that are not last are taken one per cycle; both hashes advance in
// that cycle. A last add or lookup goes through the load, probe and done
// states; the probe reads one slot per cycle from the single read port of
// the slot memory. A clear walks the whole memory, one slot per cycle.
// in_ch.ready stays low from the last byte until the result is loaded into
// the output register. After reset the same sweep runs with in_ch.ready
// low; config writes are taken throughout.
// The output register holds a result until out_ch.ready; the next key's
// bytes are still taken meanwhile, and a new result waits until the
// register frees.
module string_hash_table_probe import shtp_pkg::*; #(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  shtp_req_if.sink          in_ch,
  shtp_rsp_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  shtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_op    (in_ch.op),
    .in_last  (in_ch.last),
    .sts      (sts),
    .cmd      (cmd)
  );

  shtp_datapath #(
    .TABLE_BITS(TABLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_has_byte (in_ch.has_byte),
    .in_key_byte (in_ch.key_byte),
    .in_last     (in_ch.last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_slot    (out_ch.slot)
  );

endmodule

// ----- rtl/shtp_datapath.sv -----
module shtp_datapath import shtp_pkg::*; #(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic                in_has_byte,
  input  logic [BYTE_W-1:0]   in_key_byte,
  input  logic                in_last,
  input  logic                cfg_wr_en,
  input  logic [SIZE_W-1:0]   cfg_wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot
);

  localparam int DEPTH = 1 << TABLE_BITS;

  logic [SIZE_W-1:0]     size_r;
  hash_pair_t            ofs_r, ofs_nxt;
  hash_pair_t            tag_h_r, tag_h_nxt;
  hash_pair_t            ofs_mix, tag_mix;
  logic [BYTE_W-1:0]     ch_up;
  logic [TABLE_BITS-1:0] mask;
  logic [TABLE_BITS-1:0] start_r;
  logic [TAG_W-1:0]      tag_r;
  logic [TABLE_BITS-1:0] pos_r;
  logic [TABLE_BITS-1:0] next_pos;
  logic [TABLE_BITS-1:0] sweep_r;
  logic [TABLE_BITS-1:0] rd_addr;
  logic [TABLE_BITS-1:0] wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic                  wr_en;
  logic [ENTRY_W-1:0]    rdata_r;
  logic [ENTRY_W-1:0]    mem [DEPTH];
  logic [SLOT_W+TABLE_BITS-1:0] slot_ext;
  status_t               res_status_r;
  logic [SLOT_W-1:0]     res_slot_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(SIZE_RST);
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // Probe mask: at least one bit, at most the full table
  always_comb begin
    for (int i = 0; i < TABLE_BITS; i++) begin
      mask[i] = (i == 0) || (i < int'(size_r));
    end
  end

  // Upper-case the byte and mix both hashes
  always_comb begin
    ch_up = in_key_byte;
    if (in_key_byte >= 8'h61 && in_key_byte <= 8'h7A) begin
      ch_up = in_key_byte - 8'h20;
    end
    ofs_mix   = hash_mix(ofs_r, OFS_ROM[ch_up], ch_up);
    tag_mix   = hash_mix(tag_h_r, TAG_ROM[ch_up], ch_up);
    ofs_nxt   = in_has_byte ? ofs_mix : ofs_r;
    tag_h_nxt = in_has_byte ? tag_mix : tag_h_r;
  end

  // Running hashes: reseed after the final byte of a key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r   <= '{one: SEED_A, two: SEED_B};
      tag_h_r <= '{one: SEED_A, two: SEED_B};
    end else if (cmd.accept) begin
      if (in_last) begin
        ofs_r   <= '{one: SEED_A, two: SEED_B};
        tag_h_r <= '{one: SEED_A, two: SEED_B};
      end else begin
        ofs_r   <= ofs_nxt;
        tag_h_r <= tag_h_nxt;
      end
    end
  end

  // Capture probe start and tag on the final byte
  always_ff @(posedge clk) begin
    if (cmd.accept && in_last) begin
      start_r <= ofs_nxt.one[TABLE_BITS-1:0] & mask;
      tag_r   <= tag_h_nxt.one[TAG_W-1:0];
    end
  end

  // Probe address walk
  assign next_pos = (pos_r + TABLE_BITS'(1)) & mask;
  assign rd_addr  = cmd.probe_step ? next_pos : start_r;

  always_ff @(posedge clk) begin
    if (cmd.probe_load) begin
      pos_r <= start_r;
    end else if (cmd.probe_step) begin
      pos_r <= next_pos;
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_step) begin
      sweep_r <= sweep_r + TABLE_BITS'(1);
    end
  end

  // Slot memory: one write port, one registered read port
  assign wr_en   = cmd.wr_tag || cmd.sweep_step;
  assign wr_addr = cmd.sweep_step ? sweep_r : pos_r;
  assign wr_data = cmd.sweep_step ? '0 : {1'b1, tag_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  assign sts.occupied   = rdata_r[ENTRY_W-1];
  assign sts.tag_hit    = (rdata_r[TAG_W-1:0] == tag_r);
  assign sts.wrap       = (next_pos == start_r);
  assign sts.sweep_last = (sweep_r == {TABLE_BITS{1'b1}});
  assign sts.out_free   = !out_valid_r || out_ready;

  // Pending result
  assign slot_ext = {{SLOT_W{1'b0}}, pos_r};

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= cmd.res_use_pos ? slot_ext[SLOT_W-1:0] : '0;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

// ----- rtl/shtp_ctrl.sv -----
module shtp_ctrl import shtp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_op,
  input  logic            in_last,
  input  dp_sts_t         sts,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;
  op_t    op_r;
  logic   fire;

  assign in_ready = (state_r == S_IDLE);
  assign fire     = in_valid && in_ready;

  // Latch the operation of the final byte
  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      op_r <= op_t'(in_op);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (fire && in_last) begin
          case (op_t'(in_op))
            OP_ADD, OP_LOOKUP: state_nxt = S_LOAD;
            OP_CLEAR:          state_nxt = S_SWEEP;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: state_nxt = S_PROBE;
      S_PROBE: begin
        if (op_r == OP_ADD) begin
          if (!sts.occupied || sts.wrap) state_nxt = S_DONE;
        end else begin
          if (!sts.occupied || sts.tag_hit || sts.wrap) state_nxt = S_DONE;
        end
      end
      S_SWEEP: begin
        if (sts.sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    cmd.res_status = ST_ADDED;
    case (state_r)
      S_INIT: cmd.sweep_step = 1'b1;
      S_IDLE: cmd.accept = fire;
      S_LOAD: cmd.probe_load = 1'b1;
      S_PROBE: begin
        if (op_r == OP_ADD) begin
          if (!sts.occupied) begin
            cmd.wr_tag      = 1'b1;
            cmd.res_set     = 1'b1;
            cmd.res_use_pos = 1'b1;
            cmd.res_status  = ST_ADDED;
          end else if (sts.wrap) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_FULL;
          end else begin
            cmd.probe_step = 1'b1;
          end
        end else begin
          if (!sts.occupied) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_ABSENT;
          end else if (sts.tag_hit) begin
            cmd.res_set     = 1'b1;
            cmd.res_use_pos = 1'b1;
            cmd.res_status  = ST_FOUND;
          end else if (sts.wrap) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_ABSENT;
          end else begin
            cmd.probe_step = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_CLEARED;
        end
      end
      S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/shtp_checker.sv -----
module shtp_checker import shtp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [SLOT_W-1:0]   out_slot
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("result changed while stalled");

  // Block requests out of reset, when the memory sweep begins
  a_init_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during reset sweep");

  // Drop ready only after taking a final byte
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready && in_last))
    else $error("ready fell without a final byte");

  // Miss, full and clear results carry slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_ABSENT ||
                  out_status == ST_CLEARED) |-> out_slot == '0)
    else $error("nonzero slot on a result without a slot");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_CLEARED)
    else $error("undefined status code");

endmodule

bind string_hash_table_probe shtp_checker u_shtp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_slot   (out_ch.slot)
);

// ----- sim/string_hash_table_probe_test.sv -----
`timescale 1ns / 1ps

module string_hash_table_probe_test;
  import shtp_pkg::*;

  localparam int SLOTS       = 1 << TABLE_BITS_DEF;
  localparam int QUIET_LIMIT = 40000;
  localparam int SETTLE      = 64;
  localparam int RAND_ITEMS  = 1525;

  // One row of the directed stimulus
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    op_t               op;
    logic              has;
    logic [BYTE_W-1:0] kb;
    logic              last;
    logic              typed;
    status_t           st;
    logic [SLOT_W-1:0] slot;
  } probe_row_t;

  typedef struct packed {
    status_t           st;
    logic [SLOT_W-1:0] slot;
  } outcome_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] bytes;
  } key_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;

  shtp_req_if in_if();
  shtp_rsp_if out_if();

  string_hash_table_probe dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Mirror of the block state
  logic [31:0]        crypt_words [0:511];
  logic [31:0]        ofs_one, ofs_two, tag_one, tag_two;
  logic [ENTRY_W-1:0] slot_mem [0:SLOTS-1];
  logic [SIZE_W-1:0]  size_sel;

  outcome_t   pending_outcomes[$];
  key_t       key_pool[$];
  probe_row_t directed_rows [0:22];

  int  fails = 0;
  int  quiet_cycles = 0;
  int  sent_items = 0;
  bit  steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fill the crypt words from the seed sequence
  task automatic fill_crypt_words();
    logic [31:0] s;
    logic [15:0] hi;
    s = CRYPT_INIT;
    for (int a = 0; a < 256; a++) begin
      for (int k = 0; k < 2; k++) begin
        s  = (s * CRYPT_MUL + CRYPT_ADD) % CRYPT_MOD;
        hi = s[15:0];
        s  = (s * CRYPT_MUL + CRYPT_ADD) % CRYPT_MOD;
        crypt_words[a + k * 256] = {hi, s[15:0]};
      end
      // skip the three unused hash types
      for (int k = 0; k < 6; k++) begin
        s = (s * CRYPT_MUL + CRYPT_ADD) % CRYPT_MOD;
      end
    end
  endtask

  task automatic reseed();
    ofs_one = SEED_A;
    ofs_two = SEED_B;
    tag_one = SEED_A;
    tag_two = SEED_B;
  endtask

  task automatic stir(inout logic [31:0] one, inout logic [31:0] two,
                      input logic [31:0] word, input logic [7:0] ch);
    logic [31:0] n1;
    n1  = word ^ (one + two);
    two = {24'h0, ch} + n1 + two + (two << 5) + 32'd3;
    one = n1;
  endtask

  // Advance the mirror by one request; report the result it causes
  task automatic predict_probe(input op_t op, input logic has, input logic [7:0] kb,
                               input logic last, output bit emits, output outcome_t res);
    logic [7:0]        ch;
    int                bits;
    logic [SLOT_W-1:0] mask, start, pos;
    logic [TAG_W-1:0]  tag;
    bit                done;
    emits    = 1'b0;
    res.st   = ST_ADDED;
    res.slot = '0;
    if (has) begin
      ch = kb;
      if (ch >= 8'h61 && ch <= 8'h7A) ch = ch - 8'h20;
      stir(ofs_one, ofs_two, crypt_words[ch], ch);
      stir(tag_one, tag_two, crypt_words[256 + ch], ch);
    end
    if (last) begin
      bits = size_sel;
      if (bits < 1) bits = 1;
      if (bits > TABLE_BITS_DEF) bits = TABLE_BITS_DEF;
      mask  = SLOT_W'((1 << bits) - 1);
      start = ofs_one[SLOT_W-1:0] & mask;
      tag   = tag_one[TAG_W-1:0];
      reseed();
      pos  = start;
      done = 1'b0;
      case (op)
        OP_CLEAR: begin
          for (int i = 0; i < SLOTS; i++) slot_mem[i] = '0;
          emits  = 1'b1;
          res.st = ST_CLEARED;
        end
        OP_ADD: begin
          emits = 1'b1;
          while (slot_mem[pos][TAG_W] && !done) begin
            pos = (pos + 1'b1) & mask;
            if (pos == start) begin
              res.st = ST_FULL;
              done   = 1'b1;
            end
          end
          if (res.st == ST_ADDED) begin
            slot_mem[pos] = {1'b1, tag};
            res.slot      = pos;
          end
        end
        OP_LOOKUP: begin
          emits  = 1'b1;
          res.st = ST_ABSENT;
          while (slot_mem[pos][TAG_W] && !done) begin
            if (slot_mem[pos][TAG_W-1:0] == tag) begin
              res.st   = ST_FOUND;
              res.slot = pos;
              done     = 1'b1;
            end else begin
              pos = (pos + 1'b1) & mask;
              if (pos == start) done = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // Offer one request, idling at random first; returns at the edge that takes it
  task automatic push_req(input op_t op, input logic has, input logic [7:0] kb,
                          input logic last, input logic typed, input status_t st,
                          input logic [SLOT_W-1:0] slot);
    bit       emits;
    outcome_t res;
    while (!steady && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.has_byte <= has;
    in_if.key_byte <= kb;
    in_if.last     <= last;
    do @(posedge clk); while (!in_if.ready);
    sent_items++;
    predict_probe(op, has, kb, last, emits, res);
    if (typed) begin
      res.st   = st;
      res.slot = slot;
    end
    if (emits) pending_outcomes.push_back(res);
  endtask

  // Hold off until every result is back and the block is idle, then write the size
  task automatic settle_and_resize(input logic [SIZE_W-1:0] v);
    in_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_sel  = v;
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) < 7)
      return 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
    return 8'($urandom_range(255));
  endfunction

  function automatic key_t make_key();
    key_t k;
    k.bytes = '0;
    if ($urandom_range(9) == 0) k.len = 4'd0;
    else if ($urandom_range(9) == 0) k.len = 4'($urandom_range(7, 8));
    else k.len = 4'($urandom_range(1, 6));
    for (int i = 0; i < 8; i++) k.bytes[8*i +: 8] = pick_byte();
    return k;
  endfunction

  // Send a key byte by byte; noise and a split last item mixed in at random
  task automatic send_key(input op_t op, input key_t k);
    bit split;
    split = (k.len == 0) || ($urandom_range(99) < 15);
    for (int i = 0; i < k.len; i++) begin
      if ($urandom_range(9) == 0)
        push_req(op_t'($urandom_range(3)), 1'b0, 8'($urandom_range(255)), 1'b0,
                 1'b0, ST_ADDED, '0);
      push_req((i == k.len - 1) ? op : op_t'($urandom_range(3)), 1'b1, k.bytes[8*i +: 8],
               (i == k.len - 1) && !split, 1'b0, ST_ADDED, '0);
    end
    if (split) push_req(op, 1'b0, 8'($urandom_range(255)), 1'b1, 1'b0, ST_ADDED, '0);
  endtask

  // Result side: check each accepted result, stall at random
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", out_if.status, out_if.slot);
        fails++;
      end else begin
        e = pending_outcomes.pop_front();
        if (out_if.status !== e.st) begin
          $error("status: expected %0d, actual %0d", e.st, out_if.status);
          fails++;
        end
        if (out_if.slot !== e.slot) begin
          $error("slot: expected %0d, actual %0d", e.slot, out_if.slot);
          fails++;
        end
      end
    end
    out_if.ready <= steady || ($urandom_range(99) >= 12);
  end

  // Count cycles in which no request and no result moves
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    key_t        k;
    int          counted;
    int          first_rand;
    int          pick;
    int          phase;
    logic [3:0]  phase_sizes [0:7];

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.op       = OP_ADD;
    in_if.has_byte = 1'b0;
    in_if.key_byte = '0;
    in_if.last     = 1'b0;
    out_if.ready   = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;

    fill_crypt_words();
    reseed();
    for (int i = 0; i < SLOTS; i++) slot_mem[i] = '0;
    size_sel = SIZE_RST;

    directed_rows = '{
      '{4'd12, OP_LOOKUP, 1'b1, 8'h41, 1'b1, 1'b1, ST_ABSENT,  12'd0},
      '{4'd12, OP_ADD,    1'b1, 8'h61, 1'b0, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_ADD,    1'b1, 8'h62, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_LOOKUP, 1'b1, 8'h41, 1'b0, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_LOOKUP, 1'b1, 8'h42, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_LOOKUP, 1'b0, 8'hFF, 1'b0, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_LOOKUP, 1'b1, 8'h00, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_ADD,    1'b1, 8'hFF, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_ADD,    1'b0, 8'h00, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_LOOKUP, 1'b0, 8'h5A, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_NONE,   1'b1, 8'h7A, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_NONE,   1'b1, 8'h7A, 1'b0, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_LOOKUP, 1'b1, 8'h80, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd12, OP_CLEAR,  1'b1, 8'hAA, 1'b1, 1'b1, ST_CLEARED, 12'd0},
      '{4'd12, OP_LOOKUP, 1'b0, 8'h55, 1'b1, 1'b1, ST_ABSENT,  12'd0},
      '{4'd1,  OP_ADD,    1'b1, 8'h01, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd1,  OP_ADD,    1'b1, 8'h02, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd1,  OP_ADD,    1'b1, 8'h03, 1'b1, 1'b1, ST_FULL,    12'd0},
      '{4'd1,  OP_LOOKUP, 1'b1, 8'h04, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd0,  OP_ADD,    1'b1, 8'h05, 1'b1, 1'b1, ST_FULL,    12'd0},
      '{4'd15, OP_ADD,    1'b1, 8'h41, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd15, OP_LOOKUP, 1'b1, 8'h61, 1'b1, 1'b0, ST_ADDED,   12'd0},
      '{4'd15, OP_CLEAR,  1'b0, 8'h00, 1'b1, 1'b1, ST_CLEARED, 12'd0}
    };
    phase_sizes = '{4'd1, 4'd12, 4'd3, 4'd0, 4'd15, 4'd2, 4'd7, 4'd13};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: change the size only where a row asks for a new one
    foreach (directed_rows[i]) begin
      if (directed_rows[i].size != size_sel) settle_and_resize(directed_rows[i].size);
      push_req(directed_rows[i].op, directed_rows[i].has, directed_rows[i].kb,
               directed_rows[i].last, directed_rows[i].typed, directed_rows[i].st,
               directed_rows[i].slot);
    end

    // Random keys in phases, one table size per phase
    counted    = 0;
    phase      = 0;
    first_rand = sent_items;
    while (counted < RAND_ITEMS) begin
      if (counted >= phase * 200) begin
        settle_and_resize(phase_sizes[phase % 8]);
        phase++;
      end
      steady = (counted >= 600 && counted < 900);
      pick = $urandom_range(99);
      if (pick < 40) begin
        k = make_key();
        send_key(OP_ADD, k);
        key_pool.push_back(k);
        if (key_pool.size() > 64) void'(key_pool.pop_front());
      end else if (pick < 75 && key_pool.size() != 0) begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
        // letters match in either case
        for (int i = 0; i < 8; i++) begin
          if (((k.bytes[8*i +: 8] | 8'h20) >= 8'h61) && ((k.bytes[8*i +: 8] | 8'h20) <= 8'h7A)
              && $urandom_range(1))
            k.bytes[8*i + 5] = ~k.bytes[8*i + 5];
        end
        send_key(OP_LOOKUP, k);
      end else if (pick < 85) begin
        send_key(OP_LOOKUP, make_key());
      end else if (pick < 88 && key_pool.size() != 0) begin
        send_key(OP_ADD, key_pool[$urandom_range(key_pool.size() - 1)]);
      end else if (pick < 90) begin
        send_key(OP_CLEAR, make_key());
      end else if (pick < 95) begin
        send_key(OP_NONE, make_key());
      end else begin
        // broken sequence: bytes with no last, the next key absorbs them
        k = make_key();
        for (int i = 0; i < k.len; i++)
          push_req(op_t'($urandom_range(3)), 1'b1, k.bytes[8*i +: 8], 1'b0,
                   1'b0, ST_ADDED, '0);
      end
      counted = sent_items - first_rand;
    end
    steady = 1'b0;

    // Drain and let the block go quiet
    in_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $error("results missing: %0d", pending_outcomes.size());
      fails++;
    end
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
